// ===== design/per_channel_pedestal_subtractor_core_macros.svh =====
// Assertion macros shared by the checker of the pedestal subtractor.
// Depends on nothing; the including file supplies clock and disable terms.
`ifndef PER_CHANNEL_PEDESTAL_SUBTRACTOR_CORE_MACROS_SVH
`define PER_CHANNEL_PEDESTAL_SUBTRACTOR_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PSS_ASSERT_NOW(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("pedestal subtractor check failed");

// Antecedent implies consequent in the following cycle.
`define PSS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("pedestal subtractor check failed");

`endif

// ===== design/pss_pkg.sv =====
// Package of the per-channel pedestal subtractor: types, codes and defaults.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none
package pss_pkg;

   localparam int BOARDS_DEF      = 4;
   localparam int MODULES_DEF     = 8;
   localparam int CHANNELS_DEF    = 4;
   localparam int SLICES_DEF      = 4;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int TALLY_BITS_DEF  = 16;

   localparam int IN_BITS     = 24;
   localparam int OFFSET_BITS = 24;
   localparam int VALUE_BITS  = 25;
   localparam int IDX_BITS    = 16;

   typedef enum logic [1:0] {
      MODE_ADD     = 2'd0,
      MODE_CORRECT = 2'd1,
      MODE_CLEAR   = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_ILLEGAL   = 2'd1,
      STAT_SATURATED = 2'd2
   } status_type;

   typedef enum logic {
      CSR_MEASURE = 1'b0,
      CSR_CORRECT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC,
      BK_DIVIDE,
      BK_REPLY
   } back_state_type;

   typedef struct packed {
      mode_type             mode;
      logic                 legal;
      logic [IDX_BITS-1:0]  idx;
      logic [IN_BITS-1:0]   smp;
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/pss_div.sv =====
// Restoring divider, one quotient bit per cycle, for the channel average.
// Depends on nothing outside this file.
`default_nettype none
module pss_div #(
   parameter int SW = 40,
   parameter int TW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [SW-1:0] dividend,
   input  wire logic [TW-1:0] divisor,
   output logic               done,
   output logic [SW-1:0]      quotient
);
   localparam int CW = $clog2(SW + 1);

   logic [SW-1:0] quo_ff, quo_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [TW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [TW:0]   trial;
   logic [TW:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[SW-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(SW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[TW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = trial[TW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== design/pss_front.sv =====
// Front end: accepts request beats, checks and flattens the channel index,
// and holds commands in a two-entry queue. Depends on pss_pkg.
`default_nettype none
module pss_front #(
   parameter int BOARDS      = pss_pkg::BOARDS_DEF,
   parameter int MODULES     = pss_pkg::MODULES_DEF,
   parameter int CHANNELS    = pss_pkg::CHANNELS_DEF,
   parameter int SLICES      = pss_pkg::SLICES_DEF,
   parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [3:0]                    req_board,
   input  wire logic [3:0]                    req_module_req,
   input  wire logic [3:0]                    req_channel,
   input  wire logic [3:0]                    req_slice,
   input  wire logic [pss_pkg::IN_BITS-1:0]   req_sample,
   input  wire logic                          hold,
   input  wire logic                          cmd_pop,
   output logic                               cmd_valid,
   output pss_pkg::cmd_type                   cmd
);
   localparam logic [pss_pkg::IN_BITS-1:0] SMP_MASK = (SAMPLE_BITS >= pss_pkg::IN_BITS) ?
      {pss_pkg::IN_BITS{1'b1}} : pss_pkg::IN_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

   pss_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   pss_pkg::cmd_type incoming;
   logic             legal;
   logic [31:0]      idx_full;
   logic             push_ok;

   always_comb begin
      legal = (32'(req_board) < BOARDS) && (32'(req_module_req) < MODULES) &&
              (32'(req_channel) < CHANNELS) && (32'(req_slice) < SLICES);
      idx_full = ((32'(req_board) * MODULES + 32'(req_module_req)) * CHANNELS +
                  32'(req_channel)) * SLICES + 32'(req_slice);
      incoming.mode  = pss_pkg::mode_type'(req_mode);
      incoming.legal = legal;
      incoming.idx   = legal ? idx_full[pss_pkg::IDX_BITS-1:0] : '0;
      incoming.smp   = req_sample & SMP_MASK;
   end

   assign req_full  = (cnt_ff == 2'd2) || hold;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (cmd_pop && cmd_valid);
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end
endmodule
`default_nettype wire

// ===== design/pss_back.sv =====
// Back end: calibration stores, sequencer, divider and the result register.
// Depends on pss_pkg and pss_div.
`default_nettype none
module pss_back #(
   parameter int BOARDS      = pss_pkg::BOARDS_DEF,
   parameter int MODULES     = pss_pkg::MODULES_DEF,
   parameter int CHANNELS    = pss_pkg::CHANNELS_DEF,
   parameter int SLICES      = pss_pkg::SLICES_DEF,
   parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF,
   parameter int TALLY_BITS  = pss_pkg::TALLY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic                              csr_wdata,
   input  wire logic                              cmd_valid,
   input  wire pss_pkg::cmd_type                  cmd,
   output logic                                   cmd_pop,
   output logic                                   clearing,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic signed [pss_pkg::VALUE_BITS-1:0]  rsp_value,
   output logic [1:0]                             rsp_status
);
   localparam int ENTRIES = BOARDS * MODULES * CHANNELS * SLICES;
   localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW      = SAMPLE_BITS + TALLY_BITS;
   localparam int OW      = pss_pkg::OFFSET_BITS;
   localparam int VW      = pss_pkg::VALUE_BITS;

   logic [SW-1:0]         sum_mem [ENTRIES];
   logic [TALLY_BITS-1:0] tally_mem [ENTRIES];
   logic [OW-1:0]         off_mem [ENTRIES];

   pss_pkg::back_state_type state_ff, state_in;

   logic [SW-1:0]         rd_sum_ff;
   logic [TALLY_BITS-1:0] rd_tally_ff;
   logic [OW-1:0]         rd_off_ff;
   logic [IW-1:0]         rd_addr;

   logic                  mem_we;
   logic [IW-1:0]         wr_addr;
   logic [SW-1:0]         wr_sum;
   logic [TALLY_BITS-1:0] wr_tally;
   logic [OW-1:0]         wr_off;

   pss_pkg::cmd_type      cur_ff;
   logic [IW-1:0]         clr_ptr_ff;
   logic                  clr_cmd_ff;
   logic                  measure_ff;
   logic                  correct_ff;
   logic [SW-1:0]         new_sum_ff;
   logic [TALLY_BITS-1:0] new_tally_ff;
   logic [VW-1:0]         res_value_ff, res_value_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [VW-1:0]         out_value_ff;
   logic [1:0]            out_status_ff;
   logic                  out_valid_ff;

   logic                  clr_last;
   logic                  saturated;
   logic                  add_go;
   logic                  corr_on;
   logic [SW-1:0]         sum_next;
   logic [TALLY_BITS-1:0] tally_next;
   logic                  div_start;
   logic                  div_done;
   logic [SW-1:0]         div_quo;
   logic [OW-1:0]         new_off;
   logic                  out_free;

   pss_div #(.SW(SW), .TW(TALLY_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (tally_next),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      clr_last   = (clr_ptr_ff == IW'(ENTRIES - 1));
      saturated  = (rd_tally_ff == {TALLY_BITS{1'b1}});
      add_go     = (cur_ff.mode == pss_pkg::MODE_ADD) && cur_ff.legal && !saturated;
      corr_on    = correct_ff && !measure_ff;
      sum_next   = rd_sum_ff + SW'(cur_ff.smp);
      tally_next = rd_tally_ff + TALLY_BITS'(1);
      new_off    = OW'(div_quo);
      out_free   = !out_valid_ff || rsp_pop;
      rd_addr    = cmd.idx[IW-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pss_pkg::BK_CLEAR: begin
            if (clr_last) begin
               state_in = clr_cmd_ff ? pss_pkg::BK_REPLY : pss_pkg::BK_IDLE;
            end
         end
         pss_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.mode == pss_pkg::MODE_CLEAR) ?
                          pss_pkg::BK_CLEAR : pss_pkg::BK_EXEC;
            end
         end
         pss_pkg::BK_EXEC: begin
            state_in = add_go ? pss_pkg::BK_DIVIDE : pss_pkg::BK_REPLY;
         end
         pss_pkg::BK_DIVIDE: begin
            if (div_done) begin
               state_in = pss_pkg::BK_REPLY;
            end
         end
         pss_pkg::BK_REPLY: begin
            if (out_free) begin
               state_in = pss_pkg::BK_IDLE;
            end
         end
         default: state_in = pss_pkg::BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      cmd_pop       = 1'b0;
      div_start     = 1'b0;
      mem_we        = 1'b0;
      wr_addr       = cur_ff.idx[IW-1:0];
      wr_sum        = new_sum_ff;
      wr_tally      = new_tally_ff;
      wr_off        = new_off;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         pss_pkg::BK_CLEAR: begin
            mem_we   = 1'b1;
            wr_addr  = clr_ptr_ff;
            wr_sum   = '0;
            wr_tally = '0;
            wr_off   = '0;
         end
         pss_pkg::BK_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               res_value_in  = '0;
               res_status_in = pss_pkg::STAT_OK;
            end
         end
         pss_pkg::BK_EXEC: begin
            div_start = add_go;
            case (cur_ff.mode)
               pss_pkg::MODE_ADD: begin
                  if (!cur_ff.legal) begin
                     res_status_in = pss_pkg::STAT_ILLEGAL;
                  end else if (saturated) begin
                     res_value_in  = VW'(rd_off_ff);
                     res_status_in = pss_pkg::STAT_SATURATED;
                  end
               end
               pss_pkg::MODE_CORRECT: begin
                  res_value_in = VW'(cur_ff.smp);
                  if (corr_on && !cur_ff.legal) begin
                     res_status_in = pss_pkg::STAT_ILLEGAL;
                  end else if (corr_on) begin
                     res_value_in = VW'(cur_ff.smp) - VW'(rd_off_ff);
                  end
               end
               default: res_value_in = '0;
            endcase
         end
         pss_pkg::BK_DIVIDE: begin
            if (div_done) begin
               mem_we       = 1'b1;
               res_value_in = VW'(new_off);
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[wr_addr]   <= wr_sum;
         tally_mem[wr_addr] <= wr_tally;
         off_mem[wr_addr]   <= wr_off;
      end
      rd_sum_ff   <= sum_mem[rd_addr];
      rd_tally_ff <= tally_mem[rd_addr];
      rd_off_ff   <= off_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::BK_CLEAR;
         clr_ptr_ff   <= '0;
         clr_cmd_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         measure_ff   <= 1'b0;
         correct_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (state_ff == pss_pkg::BK_CLEAR) begin
            clr_ptr_ff <= clr_last ? '0 : clr_ptr_ff + IW'(1);
         end
         if (cmd_pop) begin
            clr_cmd_ff <= 1'b1;
         end
         if (state_ff == pss_pkg::BK_REPLY && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we && pss_pkg::csr_type'(csr_index) == pss_pkg::CSR_MEASURE) begin
            measure_ff <= csr_wdata;
         end
         if (csr_we && pss_pkg::csr_type'(csr_index) == pss_pkg::CSR_CORRECT) begin
            correct_ff <= csr_wdata;
         end
      end
      if (cmd_pop) begin
         cur_ff <= cmd;
      end
      if (div_start) begin
         new_sum_ff   <= sum_next;
         new_tally_ff <= tally_next;
      end
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (state_ff == pss_pkg::BK_REPLY && out_free) begin
         out_value_ff  <= res_value_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign clearing   = (state_ff == pss_pkg::BK_CLEAR);
   assign rsp_empty  = !out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;
endmodule
`default_nettype wire

// ===== design/per_channel_pedestal_subtractor_core.sv =====
// Per-channel pedestal subtractor: request queue, channel stores, divider.
// Depends on pss_pkg, pss_front and pss_back.
//
// Requests enter as beats on req_* (push/full) and results leave as beats on
// rsp_* (empty/pop), exactly one result per request, in order. Two request
// beats can be queued while the back end works on a third and a finished
// result waits in the output register. The user writes registers through
// csr_we, csr_index and csr_wdata only while the block is idle; the block
// itself does not enforce this. A correction or a rejected request passes
// through the EXEC and REPLY states only. A calibration sample also waits
// in DIVIDE for the divider, which produces one quotient bit per cycle.
// A clear request walks all BOARDS*MODULES*CHANNELS*SLICES entries at one a
// cycle (512 by default). After reset the same pass runs, req_full held high.
// When the receiver stalls, the result holds on rsp_* and the back end waits
// with its next result; requests are still queued until the queue fills.
`default_nettype none
module per_channel_pedestal_subtractor_core #(
   parameter int BOARDS      = pss_pkg::BOARDS_DEF,
   parameter int MODULES     = pss_pkg::MODULES_DEF,
   parameter int CHANNELS    = pss_pkg::CHANNELS_DEF,
   parameter int SLICES      = pss_pkg::SLICES_DEF,
   parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF,
   parameter int TALLY_BITS  = pss_pkg::TALLY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [3:0]                        req_board,
   input  wire logic [3:0]                        req_module_req,
   input  wire logic [3:0]                        req_channel,
   input  wire logic [3:0]                        req_slice,
   input  wire logic [pss_pkg::IN_BITS-1:0]       req_sample,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic signed [pss_pkg::VALUE_BITS-1:0]  rsp_value,
   output logic [1:0]                             rsp_status,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic                              csr_wdata
);
   pss_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_pop;
   logic             clearing;

   pss_front #(
      .BOARDS(BOARDS), .MODULES(MODULES), .CHANNELS(CHANNELS),
      .SLICES(SLICES), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_board      (req_board),
      .req_module_req (req_module_req),
      .req_channel    (req_channel),
      .req_slice      (req_slice),
      .req_sample     (req_sample),
      .hold           (clearing),
      .cmd_pop        (cmd_pop),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd)
   );

   pss_back #(
      .BOARDS(BOARDS), .MODULES(MODULES), .CHANNELS(CHANNELS),
      .SLICES(SLICES), .SAMPLE_BITS(SAMPLE_BITS), .TALLY_BITS(TALLY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .clearing   (clearing),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );
endmodule
`default_nettype wire

// ===== design/pss_checker.sv =====
// Port-level checks of the pedestal subtractor, bound to its top level.
// Depends on the assertion macros header.
`default_nettype none
`include "per_channel_pedestal_subtractor_core_macros.svh"
module pss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [24:0] rsp_value,
   input wire logic [1:0]  rsp_status
);
   `PSS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)
   `PSS_ASSERT_NEXT(a_reset_sweep_full, clock, 1'b0, reset, req_full)
   `PSS_ASSERT_NEXT(a_stall_holds, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_value) && $stable(rsp_status))
   `PSS_ASSERT_NOW(a_status_code, clock, reset, !rsp_empty, rsp_status != 2'd3)
endmodule

bind per_channel_pedestal_subtractor_core pss_checker u_pss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_full   (req_full),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);
`default_nettype wire
